// ===== sv/timt_pkg.sv =====
// tuple id map table package: request/result structs, action and status codes, fsm states
// no dependencies
package timt_pkg;

  localparam int MAP_ENTRIES = 256;
  localparam int IDX_W = $clog2(MAP_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 48;
  localparam int DATA_W = 64;
  localparam logic [KEY_W-1:0] AUTO_KEY_LIMIT = 48'hFFFF_0000_0000;

  typedef enum logic [1:0] {
    ACT_ASSIGN = 2'd0,
    ACT_AUTO   = 2'd1,
    ACT_UNASGN = 2'd2,
    ACT_GET    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_number;
    logic [15:0] position;
    logic [63:0] data_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] key_block;
    logic [15:0] key_position;
    logic [63:0] found_data;
    logic [1:0]  status;
  } out_res_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_SCAN,
    FS_LAST,
    FS_WRITE,
    FS_OUT
  } fsm_t;

endpackage

// ===== sv/timt_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module timt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/tuple_id_map_table.sv =====
// tuple id map table top level: scan fsm over key/data rams, valid bits in flops
// depends on timt_pkg and timt_ram
//
// channel | dir | payload   | handshake
// in      | in  | in_req_t  | in_valid / in_ready
// out     | out | out_res_t | out_valid / out_ready
//
// each request scans all entries, one per cycle, through the single ram port,
// then passes through the last, write and out states before its result is offered
// auto assign repeats the scan for each skipped key
// reset clears valid bits and the auto counter at once; no clearing pass
// a waiting result holds the block; the next request is taken after it is delivered
module tuple_id_map_table
  import timt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  fsm_t state_r, state_nxt;
  in_req_t req_r;
  logic [KEY_W-1:0] key_r, key_nxt, cnt_r, cnt_nxt;
  logic [KEY_W-1:0] req_cnt_r;
  logic [MAP_ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] rd_idx_r, hit_idx_r, free_idx_r;
  logic hit_r, free_r, cmp_r;
  out_res_t res_r, res_nxt;
  logic wr_en;
  logic [IDX_W-1:0] ram_addr;
  logic [KEY_W-1:0] key_rd;
  logic [DATA_W-1:0] data_rd, hit_data_r;
  logic match;
  logic [KEY_W-1:0] c_use, c_inc;

  assign ram_addr = wr_en ? (hit_r ? hit_idx_r : free_idx_r) : scan_r[IDX_W-1:0];

  timt_ram #(.WIDTH(KEY_W), .DEPTH(MAP_ENTRIES)) u_key_ram (
    .clk(clk), .we(wr_en && !hit_r), .addr(ram_addr), .wdata(key_r), .rdata(key_rd)
  );

  timt_ram #(.WIDTH(DATA_W), .DEPTH(MAP_ENTRIES)) u_data_ram (
    .clk(clk), .we(wr_en), .addr(ram_addr), .wdata(req_r.data_value), .rdata(data_rd)
  );

  assign match = cmp_r && valid_r[rd_idx_r] && (key_rd == key_r);
  assign c_use = (cnt_r == '0) ? {{(KEY_W-1){1'b0}}, 1'b1} : cnt_r;
  assign c_inc = c_use + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE:  if (in_valid) state_nxt = FS_SCAN;
      FS_SCAN:  if (scan_r == CNT_W'(MAP_ENTRIES - 1)) state_nxt = FS_LAST;
      FS_LAST:  state_nxt = FS_WRITE;
      FS_WRITE: begin
        if (req_r.action == ACT_AUTO && hit_r && free_r) state_nxt = FS_SCAN;
        else state_nxt = FS_OUT;
      end
      FS_OUT:   if (out_ready) state_nxt = FS_IDLE;
      default:  state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    wr_en = 1'b0;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    scan_nxt = scan_r;
    if (state_r == FS_IDLE) begin
      scan_nxt = '0;
      key_nxt = {in_data.position, in_data.block_number};
      if (in_data.action == ACT_AUTO) begin
        key_nxt = {c_use[47:32] + 16'd1, c_use[31:0]};
        cnt_nxt = (c_inc >= AUTO_KEY_LIMIT) ? '0 : c_inc;
      end
    end else if (state_r == FS_SCAN) begin
      scan_nxt = scan_r + 1'b1;
    end else if (state_r == FS_WRITE) begin
      res_nxt.key_block = key_r[31:0];
      res_nxt.key_position = key_r[47:32];
      res_nxt.found_data = '0;
      res_nxt.status = ST_OK;
      scan_nxt = '0;
      case (req_r.action)
        ACT_ASSIGN: begin
          if (hit_r || free_r) wr_en = 1'b1;
          else res_nxt.status = ST_FULL;
        end
        ACT_AUTO: begin
          if (!free_r) begin
            res_nxt.status = ST_FULL;
            res_nxt.key_block = '0;
            res_nxt.key_position = '0;
          end else if (hit_r) begin
            key_nxt = {c_use[47:32] + 16'd1, c_use[31:0]};
            cnt_nxt = (c_inc >= AUTO_KEY_LIMIT) ? '0 : c_inc;
          end else begin
            wr_en = 1'b1;
          end
        end
        ACT_UNASGN: begin
          if (!hit_r) res_nxt.status = ST_NOTFOUND;
          else if (hit_data_r != req_r.data_value) res_nxt.status = ST_MISMATCH;
        end
        default: begin
          if (!hit_r) res_nxt.status = ST_NOTFOUND;
          else res_nxt.found_data = hit_data_r;
        end
      endcase
    end
  end

  // auto counter moves when the request is accepted; restore counter if the auto full check finds no free entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      valid_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FS_IDLE && in_valid) cnt_r <= cnt_nxt;
      if (state_r == FS_WRITE) begin
        if (req_r.action == ACT_AUTO && !free_r) cnt_r <= req_cnt_r;
        else cnt_r <= cnt_nxt;
        if (wr_en && !hit_r) valid_r[free_idx_r] <= 1'b1;
        if (req_r.action == ACT_UNASGN && hit_r && hit_data_r == req_r.data_value)
          valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FS_IDLE) begin
      req_r <= in_data;
      req_cnt_r <= cnt_r;
    end
    key_r <= key_nxt;
    scan_r <= scan_nxt;
    res_r <= res_nxt;
    rd_idx_r <= scan_r[IDX_W-1:0];
    cmp_r <= (state_r == FS_SCAN);
    if (state_r == FS_IDLE || state_r == FS_WRITE) begin
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (match && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_data_r <= data_rd;
      end
      if (state_r == FS_SCAN && !valid_r[scan_r[IDX_W-1:0]] && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= scan_r[IDX_W-1:0];
      end
    end
  end

  assign in_ready = (state_r == FS_IDLE);
  assign out_valid = (state_r == FS_OUT);
  assign out_data = res_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while result waits");
  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == FS_WRITE)
    else $error("ram write outside write state");
`endif

endmodule
